// File: hdl/sorted_timer_queue_defines.svh
// Assertion macros shared by the checker of the sorted timer queue.
// Holds nothing but macros; take it in with an include of the bare name.
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define STQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/stq_pkg.sv
// Package of the sorted timer queue: action and status codes, controller states
// and the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;
    localparam int unsigned ACTION_BITS = 2;
    localparam int unsigned SLOT_BITS   = 5;
    localparam int unsigned STATUS_BITS = 2;
    localparam int unsigned FIELD_BITS  = 32;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_INSERT = 2'd0,
        ACT_RETIME = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_TICK   = 2'd3
    } t_action;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REMOVE,
        S_FIND,
        S_PLACE,
        S_TICK,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted item
        logic remove;    // take the captured slot out of the order
        logic find;      // write the slot expiry, and the tag for a slot not yet valid
        logic place;     // shift the order and put the slot in
        logic set_valid;
        logic clr_valid;
        logic tick_start;
        logic tick_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;       // captured slot is in range and valid
        logic in_range;
        logic tick_due;   // entry at the tick cursor is due
        logic tick_more;  // tick cursor is below the fill count and result cap
        logic tick_next;  // entry after the tick cursor exists, is below the cap and is due
    } t_stat;
endpackage
`default_nettype wire

// File: hdl/stq_if.sv
// Valid/ready channel interface of the sorted timer queue.
// Carries an arbitrary payload type; uses no package.
`timescale 1ns / 1ps
`default_nettype none
interface stq_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/stq_datapath.sv
// Datapath of the sorted timer queue: slot storage, order list and the tick cursor.
// Depends on stq_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module stq_datapath #(
    parameter int unsigned CAPACITY  = 32,
    parameter int unsigned TIME_BITS = 32,
    parameter int unsigned TAG_BITS  = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire stq_pkg::t_cmd                 i_cmd,
    output stq_pkg::t_stat                     o_stat,
    input  wire logic [stq_pkg::SLOT_BITS-1:0] i_slot,
    input  wire logic [TIME_BITS-1:0]          i_expire,
    input  wire logic [TAG_BITS-1:0]           i_tag,
    input  wire logic [TIME_BITS-1:0]          i_now,
    output logic [stq_pkg::SLOT_BITS-1:0]      o_due_slot,
    output logic [TIME_BITS-1:0]               o_due_expire,
    output logic [TAG_BITS-1:0]                o_due_tag
);
    import stq_pkg::*;

    localparam int unsigned IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_BITS = $clog2(CAPACITY + 1);
    localparam int unsigned MAX_RESULTS = 32;
    localparam int unsigned CAP_RES = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

    logic [CAPACITY-1:0]  r_valid;
    logic [TIME_BITS-1:0] r_expire [CAPACITY];
    logic [TAG_BITS-1:0]  r_tag    [CAPACITY];
    logic [IDX_BITS-1:0]  r_order  [CAPACITY];
    logic [CNT_BITS-1:0]  r_count;

    logic [SLOT_BITS-1:0] r_slot;
    logic [TIME_BITS-1:0] r_exp;
    logic [TAG_BITS-1:0]  r_tg;
    logic [TIME_BITS-1:0] r_now;
    logic [CNT_BITS-1:0]  r_cur;

    logic                 in_range;
    logic [IDX_BITS-1:0]  slot_idx;
    logic [CAPACITY-1:0]  hit_mask;
    logic [CAPACITY-1:0]  gt_mask;
    logic [CNT_BITS-1:0]  rm_pos;
    logic [CNT_BITS-1:0]  ins_pos;
    logic [IDX_BITS-1:0]  cur_slot;
    logic [CNT_BITS-1:0]  nxt_cur;
    logic [IDX_BITS-1:0]  nxt_slot;

    assign in_range = (32'(r_slot) < CAPACITY);
    assign slot_idx = IDX_BITS'(r_slot);

    // Per-position compares: which order entry holds the slot, which expire later.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            hit_mask[i] = (CNT_BITS'(i) < r_count) && (r_order[i] == slot_idx);
            gt_mask[i]  = (CNT_BITS'(i) < r_count) && (r_expire[r_order[i]] > r_exp);
        end
    end

    // The entries are sorted, so the insert position is the count of entries not later.
    always_comb begin
        rm_pos  = '0;
        ins_pos = r_count;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (hit_mask[i]) rm_pos = CNT_BITS'(i);
            if (gt_mask[i])  ins_pos = CNT_BITS'(i);
        end
    end

    assign cur_slot = r_order[r_cur[IDX_BITS-1:0]];

    // Look one entry ahead so the final due timer can carry the last flag.
    assign nxt_cur  = r_cur + 1'b1;
    assign nxt_slot = r_order[nxt_cur[IDX_BITS-1:0]];

    always_comb begin
        o_stat.busy      = in_range && r_valid[slot_idx];
        o_stat.in_range  = in_range;
        o_stat.tick_more = (r_cur < r_count) && (r_cur < CNT_BITS'(CAP_RES));
        o_stat.tick_due  = (r_expire[cur_slot] <= r_now);
        o_stat.tick_next = (nxt_cur < r_count) && (nxt_cur < CNT_BITS'(CAP_RES)) &&
                           (r_expire[nxt_slot] <= r_now);
    end

    assign o_due_slot   = SLOT_BITS'(cur_slot);
    assign o_due_expire = r_expire[cur_slot];
    assign o_due_tag    = r_tag[cur_slot];

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slot <= i_slot;
            r_exp  <= i_expire;
            r_tg   <= i_tag;
            r_now  <= i_now;
        end
        if (i_cmd.find) begin
            r_expire[slot_idx] <= r_exp;
            if (!r_valid[slot_idx]) r_tag[slot_idx] <= r_tg;
        end
    end

    // Order list: close the gap on remove, open one on place.
    always_ff @(posedge i_clk) begin
        if (i_cmd.remove) begin
            for (int i = 0; i < CAPACITY - 1; i++)
                if (CNT_BITS'(i) >= rm_pos) r_order[i] <= r_order[i+1];
        end else if (i_cmd.place) begin
            for (int i = 1; i < CAPACITY; i++)
                if (CNT_BITS'(i) > ins_pos) r_order[i] <= r_order[i-1];
            r_order[ins_pos[IDX_BITS-1:0]] <= slot_idx;
        end
    end

    // Valid bits, fill count and tick cursor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_cur   <= '0;
        end else begin
            if (i_cmd.set_valid) r_valid[slot_idx] <= 1'b1;
            if (i_cmd.clr_valid) r_valid[slot_idx] <= 1'b0;
            if (i_cmd.remove)    r_count <= r_count - 1'b1;
            else if (i_cmd.place) r_count <= r_count + 1'b1;
            if (i_cmd.tick_start)     r_cur <= '0;
            else if (i_cmd.tick_step) r_cur <= r_cur + 1'b1;
        end
    end
endmodule
`default_nettype wire

// File: hdl/stq_ctrl.sv
// Controller of the sorted timer queue: sequences each action and drives the result.
// Depends on stq_pkg for states, codes and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module stq_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire stq_pkg::t_action         i_action,
    input  wire stq_pkg::t_stat           i_stat,
    output stq_pkg::t_cmd                 o_cmd,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [stq_pkg::STATUS_BITS-1:0] o_status,
    output logic                          o_is_expired,
    output logic                          o_last
);
    import stq_pkg::*;

    t_state  r_state, n_state;
    t_action r_act;
    logic    take;
    logic    done_ok;

    assign take    = i_in_valid && o_in_ready;
    assign done_ok = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= ACT_TICK;
        end else begin
            r_state <= n_state;
            if (take) r_act <= i_action;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (take) n_state = (i_action == ACT_TICK) ? S_TICK : S_FIND;
            S_FIND: begin
                // Check the captured slot and choose the path.
                if (!i_stat.busy && r_act != ACT_INSERT) n_state = S_DONE;
                else if (i_stat.busy && r_act == ACT_INSERT) n_state = S_DONE;
                else if (!i_stat.in_range) n_state = S_DONE;
                else if (r_act == ACT_INSERT) n_state = S_PLACE;
                else n_state = S_REMOVE;
            end
            S_REMOVE: n_state = (r_act == ACT_DELETE) ? S_DONE : S_PLACE;
            S_PLACE:  n_state = S_DONE;
            S_TICK: begin
                if (done_ok && o_last) n_state = S_IDLE;
            end
            S_DONE: if (done_ok) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: the status check happens in S_FIND before anything changes.
    logic r_err_busy, r_err_empty;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_busy  <= 1'b0;
            r_err_empty <= 1'b0;
        end else if (r_state == S_FIND) begin
            r_err_busy  <= i_stat.busy && r_act == ACT_INSERT;
            r_err_empty <= !i_stat.in_range || (!i_stat.busy && r_act != ACT_INSERT);
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_status     = ST_OK;
        o_is_expired = 1'b0;
        o_last       = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load     = take;
                o_cmd.tick_start = take;
            end
            S_FIND: begin
                o_cmd.find = i_stat.in_range &&
                             ((r_act == ACT_INSERT && !i_stat.busy) ||
                              (r_act == ACT_RETIME && i_stat.busy));
                o_cmd.set_valid = i_stat.in_range && !i_stat.busy && r_act == ACT_INSERT;
            end
            S_REMOVE: begin
                o_cmd.remove    = 1'b1;
                o_cmd.clr_valid = (r_act == ACT_DELETE);
            end
            S_PLACE: o_cmd.place = 1'b1;
            S_TICK: begin
                // A due entry is last when the one after it is not reported;
                // with nothing due at the head, one empty result ends the tick.
                o_out_valid  = 1'b1;
                o_is_expired = i_stat.tick_more && i_stat.tick_due;
                o_last       = !o_is_expired || !i_stat.tick_next;
                o_cmd.tick_step = done_ok && o_is_expired;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (r_err_busy) o_status = ST_BUSY;
                else if (r_err_empty) o_status = ST_EMPTY;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: hdl/sorted_timer_queue.sv
// Sorted timer queue: a controller and a datapath that keep up to CAPACITY timers in
// expiry order, behind one valid/ready channel for items and one for results. One item
// is handled at a time, and the input is held off until its last result is taken.
// Insert passes S_FIND and S_PLACE, re-time S_FIND, S_REMOVE and S_PLACE, and delete
// S_FIND and S_REMOVE before the result is offered in S_DONE; a rejected insert,
// re-time or delete goes from S_FIND straight to S_DONE. The order list shifts its
// entries by one position in a single update. A tick offers its first result in the
// cycle after acceptance and then, while the receiver takes them, one due timer per
// cycle, head first, last set on the final one, or one empty result if none is due.
`timescale 1ns / 1ps
`default_nettype none
module sorted_timer_queue #(
    parameter int unsigned CAPACITY  = 32,
    parameter int unsigned TIME_BITS = 32,
    parameter int unsigned TAG_BITS  = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stq_if.sink       i_in,
    stq_if.source     o_out
);
    import stq_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [SLOT_BITS-1:0]  due_slot;
    logic [TIME_BITS-1:0]  due_exp;
    logic [TAG_BITS-1:0]   due_tag;
    logic [STATUS_BITS-1:0] status;
    logic is_exp, last, walk_valid;

    stq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .i_action(t_action'(i_in.data.action)),
        .i_stat(stat), .o_cmd(cmd),
        .o_out_valid(walk_valid), .i_out_ready(o_out.ready),
        .o_status(status), .o_is_expired(is_exp), .o_last(last)
    );

    stq_datapath #(.CAPACITY(CAPACITY), .TIME_BITS(TIME_BITS), .TAG_BITS(TAG_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_slot(i_in.data.slot),
        .i_expire(TIME_BITS'(i_in.data.expire_time)),
        .i_tag(TAG_BITS'(i_in.data.user_tag)),
        .i_now(TIME_BITS'(i_in.data.now_time)),
        .o_due_slot(due_slot), .o_due_expire(due_exp), .o_due_tag(due_tag)
    );

    // Result fields; data fields are zero when no due timer is reported.
    assign o_out.valid           = walk_valid;
    assign o_out.data.status     = status;
    assign o_out.data.is_expired = is_exp;
    assign o_out.data.due_slot   = is_exp ? due_slot : '0;
    assign o_out.data.due_tag    = is_exp ? FIELD_BITS'(due_tag) : '0;
    assign o_out.data.due_expire = is_exp ? FIELD_BITS'(due_exp) : '0;
    assign o_out.data.last       = last;
endmodule
`default_nettype wire

// File: hdl/stq_checker.sv
// Port checker of the sorted timer queue, bound to the top level.
// Depends on the assertion macros header and on stq_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_timer_queue_defines.svh"
module stq_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       out_exp,
    input wire logic [1:0] out_status,
    input wire logic       out_last
);
    import stq_pkg::*;

    `STQ_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, out_valid, !(in_valid && in_ready), "input taken during result")
    `STQ_ASSERT_IMPL(a_exp_ok, i_clk, i_rst_n, out_valid && out_exp, out_status == ST_OK, "due result with error")
    `STQ_ASSERT_IMPL(a_err_last, i_clk, i_rst_n, out_valid && out_status != ST_OK, out_last, "error not last")
    `STQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid, "result withdrawn")
endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .out_exp(o_out.data.is_expired), .out_status(o_out.data.status),
    .out_last(o_out.data.last)
);
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the sorted timer queue: directed and random actions
// with a model of the sorted list. Depends on stq_pkg, stq_if and sorted_timer_queue.
`timescale 1ns / 1ps
module tb;
    import stq_pkg::*;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  slot;
        logic [31:0] expire_time;
        logic [31:0] user_tag;
        logic [31:0] now_time;
    } t_timer_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_expired;
        logic [4:0]  due_slot;
        logic [31:0] due_tag;
        logic [31:0] due_expire;
        logic        last;
    } t_timer_rsp;

    localparam int NSLOT = 32;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    stq_if #(.T(t_timer_req)) req_ch (i_clk);
    stq_if #(.T(t_timer_rsp)) rsp_ch (i_clk);

    sorted_timer_queue dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (rsp_ch)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Model state of the timer list.
    logic        mdl_valid [NSLOT];
    logic [31:0] mdl_expire[NSLOT];
    logic [31:0] mdl_tag   [NSLOT];
    logic [4:0]  mdl_order [NSLOT];
    int          mdl_count;

    t_timer_rsp pending_rsp[$];
    int         fail_cnt = 0;
    bit         idle_en = 1'b1;
    int         hold_left = 0;

    // Removes a slot from the ordered list.
    function automatic void order_drop(logic [4:0] s);
        int pos;
        pos = -1;
        for (int i = 0; i < mdl_count; i++)
            if (pos < 0 && mdl_order[i] == s) pos = i;
        if (pos < 0) return;
        for (int i = pos; i + 1 < mdl_count; i++) mdl_order[i] = mdl_order[i + 1];
        mdl_count--;
    endfunction

    // Puts a slot in after every entry with an equal or earlier expiry.
    function automatic void order_add(logic [4:0] s);
        int pos;
        pos = mdl_count;
        for (int i = mdl_count - 1; i >= 0; i--)
            if (mdl_expire[mdl_order[i]] > mdl_expire[s]) pos = i;
        for (int i = mdl_count; i > pos; i--) mdl_order[i] = mdl_order[i - 1];
        mdl_order[pos] = s;
        mdl_count++;
    endfunction

    // Applies one accepted item and queues the results it causes.
    function automatic void predict_timers(t_timer_req r);
        t_timer_rsp x;
        int n;
        x = '0;
        x.last = 1'b1;
        if (r.action == ACT_TICK) begin
            n = 0;
            for (int i = 0; i < mdl_count; i++) begin
                if (mdl_expire[mdl_order[i]] > r.now_time) break;
                x = '0;
                x.is_expired = 1'b1;
                x.due_slot   = mdl_order[i];
                x.due_tag    = mdl_tag[mdl_order[i]];
                x.due_expire = mdl_expire[mdl_order[i]];
                pending_rsp.push_back(x);
                n++;
            end
            if (n == 0) pending_rsp.push_back(x);
            else pending_rsp[pending_rsp.size() - 1].last = 1'b1;
            return;
        end
        if (r.action == ACT_INSERT) begin
            if (mdl_valid[r.slot]) begin
                x.status = ST_BUSY;
            end else begin
                mdl_valid[r.slot]  = 1'b1;
                mdl_expire[r.slot] = r.expire_time;
                mdl_tag[r.slot]    = r.user_tag;
                order_add(r.slot);
            end
        end else if (!mdl_valid[r.slot]) begin
            x.status = ST_EMPTY;
        end else begin
            order_drop(r.slot);
            if (r.action == ACT_RETIME) begin
                mdl_expire[r.slot] = r.expire_time;
                order_add(r.slot);
            end else begin
                mdl_valid[r.slot] = 1'b0;
            end
        end
        pending_rsp.push_back(x);
    endfunction

    // Receiver hold-off counter.
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // Result checker and receiver ready.
    always @(posedge i_clk) begin
        t_timer_rsp want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10) $display("unexpected result %p", rsp_ch.data);
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_ch.data !== want) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch: expected %p actual %p", want, rsp_ch.data);
                end
            end
        end
        if (hold_left > 1) rsp_ch.ready <= 1'b0;
        else rsp_ch.ready <= !(idle_en && $urandom_range(99) < 17);
    end

    // Offers one item, with random gaps, and waits for its acceptance.
    task automatic send_timer(logic [1:0] act, logic [4:0] s, logic [31:0] expv,
                              logic [31:0] tagv, logic [31:0] nowv);
        t_timer_req r;
        r = '{act, s, expv, tagv, nowv};
        while (idle_en && $urandom_range(99) < 17) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_timers(r);
    endtask

    // Lowers valid and waits until every expected result has arrived.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic test_basic_actions();
        send_timer(ACT_TICK, 0, 0, 0, 32'hFFFF_FFFF);
        send_timer(ACT_INSERT, 0, 32'd0, 32'hFFFF_FFFF, 0);
        send_timer(ACT_INSERT, 31, 32'hFFFF_FFFF, 32'd0, 0);
        send_timer(ACT_INSERT, 0, 32'd5, 32'd1, 0);
        send_timer(ACT_RETIME, 7, 32'd5, 0, 0);
        send_timer(ACT_DELETE, 7, 0, 0, 0);
        send_timer(ACT_INSERT, 3, 32'd100, 32'hA5A5_5A5A, 0);
        send_timer(ACT_INSERT, 4, 32'd100, 32'h5A5A_A5A5, 0);
        send_timer(ACT_INSERT, 5, 32'd50, 32'd3, 0);
        send_timer(ACT_TICK, 0, 0, 0, 32'd0);
        send_timer(ACT_TICK, 0, 0, 0, 32'd100);
        send_timer(ACT_RETIME, 3, 32'd100, 0, 0);
        send_timer(ACT_RETIME, 0, 32'd200, 0, 0);
        send_timer(ACT_RETIME, 31, 32'd1, 0, 0);
        send_timer(ACT_DELETE, 4, 0, 0, 0);
        send_timer(ACT_TICK, 0, 0, 0, 32'hFFFF_FFFF);
        send_timer(ACT_TICK, 0, 0, 0, 32'd99);
        drain_results();
    endtask

    // Fills every slot, then reports all of them in one tick.
    task automatic test_full_list();
        for (int s = 0; s < NSLOT; s++)
            send_timer(ACT_INSERT, s[4:0], $urandom_range(40), $urandom, 0);
        send_timer(ACT_TICK, 0, 0, 0, 32'hFFFF_FFFF);
        drain_results();
    endtask

    // Receiver holds off while ticks are offered.
    task automatic test_backpressure();
        hold_left = 300;
        for (int k = 0; k < 6; k++) send_timer(ACT_TICK, 0, 0, 0, $urandom_range(45));
        drain_results();
    endtask

    // Random mix of well-formed and failing actions.
    task automatic test_random_mix(int count);
        logic [1:0]  act;
        logic [31:0] tv;
        for (int k = 0; k < count; k++) begin
            idle_en = !(k >= count / 3 && k < count / 2);
            act = 2'($urandom_range(3));
            tv = ($urandom_range(3) == 0) ? $urandom : $urandom_range(60);
            send_timer(act, 5'($urandom_range(31)), tv, $urandom,
                       ($urandom_range(3) == 0) ? $urandom : $urandom_range(60));
        end
        idle_en = 1'b1;
        drain_results();
    endtask

    initial begin
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        rsp_ch.ready  = 1'b0;
        mdl_count = 0;
        for (int s = 0; s < NSLOT; s++) mdl_valid[s] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_actions();
        test_full_list();
        test_backpressure();
        test_random_mix(54);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a hung run.
    initial begin
        #(12 * 400000);
        $display("status: fail");
        $finish;
    end
endmodule
